/* rtl/pulldown_field_mapper_defines.svh */
// Assertion macros shared by the pulldown field mapper RTL.
`ifndef PULLDOWN_FIELD_MAPPER_DEFINES_SVH
`define PULLDOWN_FIELD_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk and quiet during reset.
`define PFM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulldown_field_mapper: check failed");

// Next-cycle implication, checked on clk and quiet during reset.
`define PFM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulldown_field_mapper: check failed");

`else

`define PFM_ASSERT_NOW(name, ante, cons)
`define PFM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

/* rtl/pfm_pkg.sv */
// Types and constants shared by the pulldown field mapper modules.
package pfm_pkg;

    // Width of the source index fields on the result port.
    localparam int SRC_BITS = 24;

    // Default width of the coded picture counter.
    localparam int INDEX_BITS_DEFAULT = 24;

    // Field mode register codes; code three behaves as normal.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_FILM   = 2'd1;
    localparam logic [1:0] MODE_RAW    = 2'd2;

    // Repeat balance thresholds before and after cadence lock.
    localparam logic signed [3:0] LOCK_SEEK = 4'sd3;
    localparam logic signed [3:0] LOCK_KEEP = 4'sd5;

    // Largest number of entries one coded picture produces.
    localparam int MAX_ENTRIES = 3;

    // Flags of one coded picture.
    typedef struct packed {
        logic top_first;
        logic repeat_first;
        logic progressive_group;
    } item_t;

    // One display-frame entry.
    typedef struct packed {
        logic [SRC_BITS-1:0] top_src;
        logic [SRC_BITS-1:0] bot_src;
        logic                err;
    } entry_t;

    // All entries produced by one coded picture, first entry in slot zero.
    typedef struct packed {
        logic [1:0]                   count;
        entry_t [MAX_ENTRIES-1:0]     ent;
    } batch_t;

endpackage

/* rtl/pulldown_field_mapper.sv */
// Top level of the pulldown field mapper: ports, input register, configuration.
`include "pulldown_field_mapper_defines.svh"

// Takes one coded picture per input transaction and gives zero to three
// display-frame entries, each naming the coded picture behind its top and
// bottom field, with last set on the final entry of a picture. A picture is
// mapped while it sits in the input register after its transaction, moves
// into the result buffer once that buffer is free, and its first entry is
// offered from then on. The single result port drains one entry a cycle
// while out_stall is low, and the input register takes the next picture
// while the entries of the one before drain. field_mode is to be written
// through the cfg port (always ready) only while no picture is in flight;
// the block itself does not enforce this. After a force-film error the
// block gives no further entries until reset.
module pulldown_field_mapper #(
    parameter int INDEX_BITS = pfm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         top_first,
    input  logic                         repeat_first,
    input  logic                         progressive_group,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pfm_pkg::SRC_BITS-1:0] top_source,
    output logic [pfm_pkg::SRC_BITS-1:0] bottom_source,
    output logic                         mode_error,
    output logic                         last
);
    import pfm_pkg::*;

    logic [1:0] field_mode_reg;
    logic       in_vld_reg, in_vld_next;
    item_t      item_reg;
    logic       accept;
    logic       move;
    logic       buf_free;
    batch_t     batch;
    entry_t     head;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_mode_reg <= MODE_NORMAL;
        else if (cfg_valid && cfg_ready)
            field_mode_reg <= cfg_data;
    end

    // Input register: a picture moves on once the result buffer can take it.
    assign move     = in_vld_reg && buf_free;
    assign in_stall = in_vld_reg && !move;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (move)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.top_first         <= top_first;
            item_reg.repeat_first      <= repeat_first;
            item_reg.progressive_group <= progressive_group;
        end
    end

    // Mapping state and entry computation.
    pfm_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .field_mode (field_mode_reg),
        .item_valid (move),
        .item       (item_reg),
        .batch      (batch)
    );

    // Result buffer.
    pfm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .batch     (batch),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .head_last (last)
    );

    assign top_source    = head.top_src;
    assign bottom_source = head.bot_src;
    assign mode_error    = head.err;

    // An entry that is not the last of its picture is followed by another.
    `PFM_ASSERT_NEXT(a_more_after_not_last, out_valid && !last && !out_stall, out_valid)
    // After the last entry leaves, nothing shows unless a picture moved in.
    `PFM_ASSERT_NEXT(a_idle_after_last, out_valid && last && !out_stall && !move, !out_valid)
    // The force-film error is a lone entry and nothing follows it.
    `PFM_ASSERT_NOW(a_error_alone, out_valid && mode_error, last)
    `PFM_ASSERT_NEXT(a_halt_after_error, out_valid && mode_error && !out_stall, !out_valid)

endmodule

/* rtl/pfm_core.sv */
// Field mapping state and the per-picture entry computation.
module pfm_core #(
    parameter int INDEX_BITS = pfm_pkg::INDEX_BITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     field_mode,
    input  logic           item_valid,
    input  pfm_pkg::item_t item,
    output pfm_pkg::batch_t batch
);
    import pfm_pkg::*;

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [INDEX_BITS-1:0] held_top_reg, held_top_next;
    logic [INDEX_BITS-1:0] held_bot_reg, held_bot_next;
    logic                  top_held_reg, top_held_next;
    logic                  bot_held_reg, bot_held_next;
    logic signed [3:0]     bal_reg, bal_next;
    logic                  locked_reg, locked_next;
    logic                  halted_reg, halted_next;

    // Entry computation and next state for the picture in the input register.
    always_comb
    begin
        logic                  rff;
        logic signed [3:0]     bal_sum;
        logic signed [3:0]     limit;
        logic [SRC_BITS-1:0]   cur;
        entry_t                e_cur;
        entry_t                e_none;

        rff     = item.repeat_first && (field_mode != MODE_RAW);
        bal_sum = bal_reg + (rff ? -4'sd1 : 4'sd1);
        limit   = locked_reg ? LOCK_KEEP : LOCK_SEEK;
        cur     = SRC_BITS'(idx_reg);
        e_cur   = '{top_src: cur, bot_src: cur, err: 1'b0};
        e_none  = '{top_src: '0, bot_src: '0, err: 1'b0};

        idx_next      = idx_reg + INDEX_BITS'(1);
        held_top_next = held_top_reg;
        held_bot_next = held_bot_reg;
        top_held_next = top_held_reg;
        bot_held_next = bot_held_reg;
        bal_next      = bal_reg;
        locked_next   = locked_reg;
        halted_next   = halted_reg;
        batch.count   = 2'd0;
        batch.ent     = {MAX_ENTRIES{e_none}};

        if (halted_reg)
        begin
            idx_next = idx_reg;
        end
        else if (field_mode == MODE_FILM)
        begin
            if (item.progressive_group)
            begin
                // Progressive material cannot be forced to film: halt.
                halted_next      = 1'b1;
                idx_next         = idx_reg;
                batch.count      = 2'd1;
                batch.ent[0]     = '{top_src: '0, bot_src: '0, err: 1'b1};
            end
            else if (bal_sum == limit)
            begin
                // Too few repeats seen: drop this frame.
                bal_next    = 4'sd0;
                locked_next = 1'b1;
            end
            else
            begin
                batch.count  = 2'd1;
                batch.ent[0] = e_cur;
                bal_next     = bal_sum;
                if (bal_sum == -limit)
                begin
                    // Too many repeats seen: show this frame twice.
                    bal_next     = 4'sd0;
                    locked_next  = 1'b1;
                    batch.count  = 2'd2;
                    batch.ent[1] = e_cur;
                end
            end
        end
        else if (item.progressive_group)
        begin
            // Whole frames: one, two with a repeat, three when top field first too.
            batch.ent   = {MAX_ENTRIES{e_cur}};
            batch.count = rff ? (item.top_first ? 2'd3 : 2'd2) : 2'd1;
        end
        else
        begin
            // Interlaced picture finishes any half entry it can.
            if (top_held_reg)
            begin
                batch.ent[0] = '{top_src: SRC_BITS'(held_top_reg), bot_src: cur, err: 1'b0};
                held_top_next = idx_reg;
            end
            else if (bot_held_reg)
            begin
                batch.ent[0] = '{top_src: cur, bot_src: SRC_BITS'(held_bot_reg), err: 1'b0};
                held_bot_next = idx_reg;
            end
            else
            begin
                batch.ent[0] = e_cur;
            end
            batch.count = 2'd1;

            // A repeated field is held for a later entry.
            if (rff)
            begin
                if (item.top_first)
                begin
                    held_top_next = idx_reg;
                    top_held_next = 1'b1;
                end
                else
                begin
                    held_bot_next = idx_reg;
                    bot_held_next = 1'b1;
                end
                if (top_held_next && bot_held_next)
                begin
                    batch.count  = 2'd2;
                    batch.ent[1] = '{top_src: SRC_BITS'(held_top_next),
                                     bot_src: SRC_BITS'(held_bot_next), err: 1'b0};
                    top_held_next = 1'b0;
                    bot_held_next = 1'b0;
                end
            end
        end
    end

    // State update once per picture taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            held_top_reg <= '0;
            held_bot_reg <= '0;
            top_held_reg <= 1'b0;
            bot_held_reg <= 1'b0;
            bal_reg      <= 4'sd0;
            locked_reg   <= 1'b0;
            halted_reg   <= 1'b0;
        end
        else if (item_valid)
        begin
            idx_reg      <= idx_next;
            held_top_reg <= held_top_next;
            held_bot_reg <= held_bot_next;
            top_held_reg <= top_held_next;
            bot_held_reg <= bot_held_next;
            bal_reg      <= bal_next;
            locked_reg   <= locked_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

/* rtl/pfm_out_buf.sv */
// Result buffer that hands out the entries of one picture, one per transaction.
module pfm_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  pfm_pkg::batch_t  batch,
    output logic             free,
    output logic             out_valid,
    input  logic             out_stall,
    output pfm_pkg::entry_t  head,
    output logic             head_last
);
    import pfm_pkg::*;

    entry_t [MAX_ENTRIES-1:0] ent_reg;
    logic [1:0]               cnt_reg, cnt_next;
    logic                     pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign free      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);
    assign head      = ent_reg[0];
    assign head_last = (cnt_reg == 2'd1);

    // Entry count: reload on a new batch, count down on each transaction.
    always_comb
    begin
        if (load)
            cnt_next = batch.count;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Entry slots shift toward the head as entries leave.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= batch.ent;
        end
        else if (pop)
        begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule

/* sim/pulldown_field_mapper_tb.sv */
// Self-checking testbench for the pulldown field mapper, with a cycle-free model of its mapping.
module pulldown_field_mapper_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Mode code three is not named in the package; the block treats it as normal.
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    // One display-frame entry as it should leave the block.
    typedef struct packed {
        logic [pfm_pkg::SRC_BITS-1:0] top_src;
        logic [pfm_pkg::SRC_BITS-1:0] bot_src;
        logic                         err;
        logic                         fin;
    } frame_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [1:0]                   cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic                         top_first;
    logic                         repeat_first;
    logic                         progressive_group;
    logic                         out_valid;
    logic                         out_stall;
    logic [pfm_pkg::SRC_BITS-1:0] top_source;
    logic [pfm_pkg::SRC_BITS-1:0] bottom_source;
    logic                         mode_error;
    logic                         last;

    // Frames still owed by the block, oldest first.
    frame_t frames_due[$];

    // Model copy of the mapper state and its mode register.
    logic [1:0]                   cur_mode;
    logic [pfm_pkg::SRC_BITS-1:0] pic_index;
    logic [pfm_pkg::SRC_BITS-1:0] hold_top_src;
    logic [pfm_pkg::SRC_BITS-1:0] hold_bot_src;
    logic                         hold_top;
    logic                         hold_bot;
    int                           rep_balance;
    logic                         cadence_lock;
    logic                         stopped;

    // Bookkeeping and traffic shaping.
    int   fail_count     = 0;
    int   checked_frames = 0;
    int   sent_pictures  = 0;
    int   film_drops     = 0;
    int   film_doubles   = 0;
    bit   send_steady    = 1'b0;
    bit   recv_steady    = 1'b0;
    logic [1:0] cadence  = 2'd0;

    pulldown_field_mapper dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .top_first         (top_first),
        .repeat_first      (repeat_first),
        .progressive_group (progressive_group),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .top_source        (top_source),
        .bottom_source     (bottom_source),
        .mode_error        (mode_error),
        .last              (last)
    );

    // Free-running 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Queue one owed frame; the end-of-picture flag is set afterwards.
    function automatic void add_frame(input logic [pfm_pkg::SRC_BITS-1:0] top_src,
                                      input logic [pfm_pkg::SRC_BITS-1:0] bot_src,
                                      input logic err);
        frame_t f;
        f.top_src = top_src;
        f.bot_src = bot_src;
        f.err     = err;
        f.fin     = 1'b0;
        frames_due.push_back(f);
    endfunction

    // Work out the frames one coded picture yields and advance the model state.
    function automatic void predict_picture(input logic tf, input logic rff_in,
                                            input logic prog);
        int   start;
        int   limit;
        logic rff;
        logic [pfm_pkg::SRC_BITS-1:0] cur;
        start = frames_due.size();
        cur   = pic_index;
        rff   = rff_in;
        if (stopped)
            return;
        if (cur_mode == pfm_pkg::MODE_RAW)
            rff = 1'b0;

        if (cur_mode == pfm_pkg::MODE_FILM)
        begin
            // A progressive group cannot be forced to film: error entry and halt.
            if (prog)
            begin
                stopped = 1'b1;
                add_frame('0, '0, 1'b1);
                frames_due[$].fin = 1'b1;
                return;
            end
            rep_balance += rff ? -1 : 1;
            limit = cadence_lock ? int'(pfm_pkg::LOCK_KEEP) : int'(pfm_pkg::LOCK_SEEK);
            if (rep_balance == limit)
            begin
                rep_balance  = 0;
                cadence_lock = 1'b1;
                film_drops++;
            end
            else
            begin
                add_frame(cur, cur, 1'b0);
                if (rep_balance == -limit)
                begin
                    rep_balance  = 0;
                    cadence_lock = 1'b1;
                    film_doubles++;
                    add_frame(cur, cur, 1'b0);
                end
            end
        end
        else if (prog)
        begin
            // Whole frames; the pending half entry is left alone.
            add_frame(cur, cur, 1'b0);
            if (rff)
            begin
                add_frame(cur, cur, 1'b0);
                if (tf)
                    add_frame(cur, cur, 1'b0);
            end
        end
        else
        begin
            // Interlaced picture: finish a pending half entry or give a plain frame.
            if (hold_top)
            begin
                add_frame(hold_top_src, cur, 1'b0);
                hold_top_src = cur;
            end
            else if (hold_bot)
            begin
                add_frame(cur, hold_bot_src, 1'b0);
                hold_bot_src = cur;
            end
            else
                add_frame(cur, cur, 1'b0);
            if (rff)
            begin
                if (tf)
                begin
                    hold_top_src = cur;
                    hold_top     = 1'b1;
                end
                else
                begin
                    hold_bot_src = cur;
                    hold_bot     = 1'b1;
                end
                if (hold_top && hold_bot)
                begin
                    add_frame(hold_top_src, hold_bot_src, 1'b0);
                    hold_top = 1'b0;
                    hold_bot = 1'b0;
                end
            end
        end

        pic_index = pic_index + 1'b1;
        if (frames_due.size() > start)
            frames_due[$].fin = 1'b1;
    endfunction

    // Offer one coded picture after a random gap and wait for its transaction.
    task automatic send_picture(input logic tf, input logic rff, input logic prog);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        top_first         <= tf;
        repeat_first      <= rff;
        progressive_group <= prog;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_picture(tf, rff, prog);
        sent_pictures++;
    endtask

    // Stop sending, let every owed frame arrive, then let the pipeline empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write the mode register while the block is idle.
    task automatic program_mode(input logic [1:0] mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_mode = mode;
        cfg_valid <= 1'b0;
    endtask

    // Normal mode from reset: progressive repeats and both kinds of half entry.
    task automatic test_normal_directed();
        send_picture(1'b0, 1'b0, 1'b1);
        send_picture(1'b0, 1'b1, 1'b1);
        send_picture(1'b1, 1'b1, 1'b1);
        send_picture(1'b1, 1'b1, 1'b0);
        send_picture(1'b1, 1'b1, 1'b1);
        send_picture(1'b0, 1'b0, 1'b0);
        send_picture(1'b0, 1'b1, 1'b0);
    endtask

    // Raw mode ignores repeat flags.
    task automatic test_raw_directed();
        program_mode(pfm_pkg::MODE_RAW);
        send_picture(1'b1, 1'b1, 1'b1);
        send_picture(1'b1, 1'b1, 1'b0);
    endtask

    // Mode code three must behave exactly as normal.
    task automatic test_alias_directed();
        program_mode(MODE_ALIAS);
        send_picture(1'b1, 1'b1, 1'b0);
        send_picture(1'b1, 1'b1, 1'b1);
    endtask

    // Force film: drop, double after lock, and state kept across a mode change.
    task automatic test_film_directed();
        program_mode(pfm_pkg::MODE_FILM);
        repeat (3) send_picture(1'b0, 1'b0, 1'b0);
        repeat (5) send_picture(1'b1, 1'b1, 1'b0);
        repeat (2) send_picture(1'b0, 1'b0, 1'b0);
        program_mode(pfm_pkg::MODE_NORMAL);
        send_picture(1'b1, 1'b0, 1'b0);
        program_mode(pfm_pkg::MODE_FILM);
        repeat (3) send_picture(1'b1, 1'b0, 1'b0);
    endtask

    // One random phase in a given mode; film phases follow a jittered 3:2 cadence.
    task automatic run_random_phase(input logic [1:0] mode, input int count,
                                    input bit hold_off);
        logic tf;
        logic rff;
        logic prog;
        program_mode(mode);
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
            begin
                send_steady = ($urandom_range(0, 3) == 0);
                recv_steady = ($urandom_range(0, 3) == 0);
            end
            if (hold_off && i == count / 2)
                settle();
            if (mode == pfm_pkg::MODE_FILM)
            begin
                prog = 1'b0;
                if ($urandom_range(0, 9) < 7)
                begin
                    cadence = cadence + 1'b1;
                    rff = cadence[0] ^ ($urandom_range(0, 6) == 0);
                    tf  = cadence[1];
                end
                else
                begin
                    rff = 1'($urandom_range(0, 1));
                    tf  = 1'($urandom_range(0, 1));
                end
            end
            else
            begin
                prog = ($urandom_range(0, 3) == 0);
                rff  = 1'($urandom_range(0, 1));
                tf   = 1'($urandom_range(0, 1));
            end
            send_picture(tf, rff, prog);
        end
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // Random traffic across every mode, film several times.
    task automatic test_random_mix();
        logic [1:0] plan [9];
        plan = '{pfm_pkg::MODE_NORMAL, pfm_pkg::MODE_FILM, pfm_pkg::MODE_RAW,
                 MODE_ALIAS, pfm_pkg::MODE_FILM, pfm_pkg::MODE_NORMAL,
                 pfm_pkg::MODE_RAW, pfm_pkg::MODE_FILM, MODE_ALIAS};
        for (int p = 0; p < 9; p++)
            run_random_phase(plan[p], $urandom_range(40, 60), p == 3);
    endtask

    // Progressive group in force film: error entry, then silence in film and normal mode.
    task automatic test_film_halt();
        program_mode(pfm_pkg::MODE_FILM);
        send_picture(1'b1, 1'b0, 1'b1);
        send_picture(1'b0, 1'b1, 1'b0);
        send_picture(1'b1, 1'b0, 1'b1);
        program_mode(pfm_pkg::MODE_NORMAL);
        send_picture(1'b1, 1'b1, 1'b1);
        send_picture(1'b0, 1'b1, 1'b0);
        settle();
    endtask

    // Result side: random stall per transaction, field-by-field comparison.
    initial
    begin : result_monitor
        frame_t want;
        int     hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("unexpected entry: top_source %0d bottom_source %0d",
                           top_source, bottom_source);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    checked_frames++;
                    if (top_source !== want.top_src)
                    begin
                        $error("top_source: expected %0d, got %0d", want.top_src, top_source);
                        fail_count++;
                    end
                    if (bottom_source !== want.bot_src)
                    begin
                        $error("bottom_source: expected %0d, got %0d",
                               want.bot_src, bottom_source);
                        fail_count++;
                    end
                    if (mode_error !== want.err)
                    begin
                        $error("mode_error: expected %0d, got %0d", want.err, mode_error);
                        fail_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0d, got %0d", want.fin, last);
                        fail_count++;
                    end
                end
                hold = recv_steady ? 0 : $urandom_range(0, 12);
            end
            else if (hold > 0)
                hold--;
            out_stall <= (hold > 0);
        end
    end

    // Watchdog for a block that hangs.
    initial
    begin
        #1_000_000;
        $display("[pulldown_field_mapper] ERROR");
        $finish;
    end

    // Reset, run each test in turn, drain and report.
    initial
    begin
        int waited;
        rst_n             <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_data          <= pfm_pkg::MODE_NORMAL;
        in_valid          <= 1'b0;
        top_first         <= 1'b0;
        repeat_first      <= 1'b0;
        progressive_group <= 1'b0;
        cur_mode     = pfm_pkg::MODE_NORMAL;
        pic_index    = '0;
        hold_top_src = '0;
        hold_bot_src = '0;
        hold_top     = 1'b0;
        hold_bot     = 1'b0;
        rep_balance  = 0;
        cadence_lock = 1'b0;
        stopped      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_normal_directed();
        test_raw_directed();
        test_alias_directed();
        test_film_directed();
        test_random_mix();
        test_film_halt();

        in_valid <= 1'b0;
        waited = 0;
        while (frames_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (frames_due.size() != 0)
        begin
            $error("%0d expected entries never arrived", frames_due.size());
            fail_count++;
        end

        $display("Sent %0d pictures through normal, raw, mode-three and force-film settings;",
                 sent_pictures);
        $display("checked %0d entries, including %0d film drops, %0d film doubles and the halt.",
                 checked_frames, film_drops, film_doubles);
        if (fail_count == 0)
            $display("[pulldown_field_mapper] OK");
        else
            $display("[pulldown_field_mapper] ERROR");
        $finish;
    end

endmodule
